>>> rtl/ued_pkg.sv
// shared types, codes and constants for the ep0 descriptor responder
// no dependencies; imported by ued_engine and usb_ep0_descriptor_responder
package ued_pkg;

  // parameter defaults
  localparam int DEF_MAX_PACKET    = 8;
  localparam int DEF_OUT_DATA_SIZE = 200;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_LEN  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_LEN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LANG_LEN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRING1_LEN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRING2_LEN = 3'd4;

  // register reset values
  localparam logic [7:0] RST_DEVICE_LEN  = 8'd18;
  localparam logic [7:0] RST_CONFIG_LEN  = 8'd67;
  localparam logic [7:0] RST_LANG_LEN    = 8'd4;
  localparam logic [7:0] RST_STRING1_LEN = 8'd52;
  localparam logic [7:0] RST_STRING2_LEN = 8'd52;

  // sie event kinds
  localparam logic [1:0] EV_BUS_RESET = 2'd0;
  localparam logic [1:0] EV_IN_DONE   = 2'd1;
  localparam logic [1:0] EV_OUT_DONE  = 2'd2;

  // token pids
  localparam logic [3:0] PID_SETUP = 4'd13;
  localparam logic [3:0] PID_OUT   = 4'd1;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'h0B;

  // descriptor types
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  // string indexes
  localparam logic [7:0] STR_LANG = 8'd0;
  localparam logic [7:0] STR_ONE  = 8'd1;
  localparam logic [7:0] STR_TWO  = 8'd2;

  // descriptor start offsets in descriptor memory
  localparam logic [7:0] DEV_START  = 8'h08;
  localparam logic [7:0] CONF_START = 8'h1A;
  localparam logic [7:0] STR0_START = 8'h5D;
  localparam logic [7:0] STR1_START = 8'h61;
  localparam logic [7:0] STR2_START = 8'h95;

  localparam logic [7:0] STATUS_OUT_SIZE = 8'd8;

  typedef enum logic [1:0] {
    XFER_NONE,
    XFER_DEVICE,
    XFER_CONFIG,
    XFER_STRING
  } xfer_kind_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  token_pid;
    logic [7:0]  request_code;
    logic [7:0]  value_high;
    logic [7:0]  value_low;
    logic [15:0] length_requested;
  } sie_event_t;

  typedef struct packed {
    xfer_kind_t  kind;
    logic [7:0]  string_index;
    logic [7:0]  bytes_remaining;
    logic [7:0]  read_offset;
  } ep_state_t;

  typedef struct packed {
    logic       arm_in;
    logic [3:0] in_count;
    logic [7:0] in_offset;
    logic       arm_out;
    logic [7:0] out_count;
  } ep_result_t;

  typedef struct packed {
    logic [7:0] device_len;
    logic [7:0] config_len;
    logic [7:0] lang_len;
    logic [7:0] string1_len;
    logic [7:0] string2_len;
  } desc_lengths_t;

endpackage

>>> rtl/usb_ep0_descriptor_responder.sv
// top level of the ep0 descriptor responder: channel registers, state and config
// depends on ued_pkg and ued_engine
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+------------------------------------
//  in      | into      | in_valid/in_stall  | one sie event with setup fields
//  out     | out of    | out_valid/out_stall| arm flags, counts and in offset
//  cfg     | into      | cfg_valid/cfg_ready| register index and 8-bit length
//
// an event passes an input register and the decode logic into the result
// register, which holds the result beat; one event per cycle is sustained
// while out_stall stays low.
// endpoint state updates as an event moves from the input register to the result
// register. rst is synchronous; lengths return to their default values.
// a stalled result holds the input register and raises in_stall; cfg is always ready.
module usb_ep0_descriptor_responder #(
  parameter int MAX_PACKET    = ued_pkg::DEF_MAX_PACKET,
  parameter int OUT_DATA_SIZE = ued_pkg::DEF_OUT_DATA_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  // event channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      event_kind,
  input  logic [3:0]                      token_pid,
  input  logic [7:0]                      request_code,
  input  logic [7:0]                      value_high,
  input  logic [7:0]                      value_low,
  input  logic [15:0]                     length_requested,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            arm_in,
  output logic [3:0]                      in_count,
  output logic [7:0]                      in_offset,
  output logic                            arm_out,
  output logic [7:0]                      out_count,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ued_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);
  import ued_pkg::*;

  sie_event_t    item;
  logic          item_valid;
  ep_state_t     state;
  ep_state_t     state_next;
  desc_lengths_t lengths;
  ep_result_t    result;
  ep_result_t    result_next;
  logic          res_advance;
  logic          in_take;

  // flow control between the two registers
  assign res_advance = item_valid && (!out_valid || !out_stall);
  assign in_stall    = item_valid && !res_advance;
  assign in_take     = in_valid && !in_stall;
  assign cfg_ready   = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (res_advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.event_kind       <= event_kind;
      item.token_pid        <= token_pid;
      item.request_code     <= request_code;
      item.value_high       <= value_high;
      item.value_low        <= value_low;
      item.length_requested <= length_requested;
    end
  end

  // decode and streaming logic
  ued_engine #(
    .MAX_PACKET    (MAX_PACKET),
    .OUT_DATA_SIZE (OUT_DATA_SIZE)
  ) u_engine (
    .item       (item),
    .state      (state),
    .lengths    (lengths),
    .result     (result_next),
    .state_next (state_next)
  );

  // endpoint state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.kind            <= XFER_NONE;
      state.string_index    <= 8'd0;
      state.bytes_remaining <= 8'd0;
      state.read_offset     <= DEV_START;
    end else if (res_advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_advance) begin
      result <= result_next;
    end
  end

  assign arm_in    = result.arm_in;
  assign in_count  = result.in_count;
  assign in_offset = result.in_offset;
  assign arm_out   = result.arm_out;
  assign out_count = result.out_count;

  // descriptor length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lengths.device_len  <= RST_DEVICE_LEN;
      lengths.config_len  <= RST_CONFIG_LEN;
      lengths.lang_len    <= RST_LANG_LEN;
      lengths.string1_len <= RST_STRING1_LEN;
      lengths.string2_len <= RST_STRING2_LEN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEVICE_LEN:  lengths.device_len  <= cfg_data;
        CFG_CONFIG_LEN:  lengths.config_len  <= cfg_data;
        CFG_LANG_LEN:    lengths.lang_len    <= cfg_data;
        CFG_STRING1_LEN: lengths.string1_len <= cfg_data;
        CFG_STRING2_LEN: lengths.string2_len <= cfg_data;
        default: begin
          lengths <= lengths;
        end
      endcase
    end
  end

endmodule

>>> rtl/ued_engine.sv
// request decode and descriptor streaming logic for one sie event
// depends on ued_pkg; purely combinational, registered by the top level
module ued_engine #(
  parameter int MAX_PACKET    = ued_pkg::DEF_MAX_PACKET,
  parameter int OUT_DATA_SIZE = ued_pkg::DEF_OUT_DATA_SIZE
) (
  input  ued_pkg::sie_event_t    item,
  input  ued_pkg::ep_state_t     state,
  input  ued_pkg::desc_lengths_t lengths,
  output ued_pkg::ep_result_t    result,
  output ued_pkg::ep_state_t     state_next
);
  import ued_pkg::*;

  localparam logic [7:0] MP       = 8'(MAX_PACKET);
  localparam logic [7:0] OUT_SIZE = 8'(OUT_DATA_SIZE);

  logic       desc_known;
  logic [7:0] desc_limit;
  logic [7:0] desc_start;
  xfer_kind_t desc_kind;
  logic [7:0] clamped;
  logic [7:0] first_len;
  logic [7:0] rem_next;
  logic [7:0] offset_next;
  logic [7:0] cont_len;

  // pick the descriptor addressed by a descriptor read request
  always_comb begin
    desc_known = 1'b1;
    desc_limit = lengths.device_len;
    desc_start = DEV_START;
    desc_kind  = XFER_DEVICE;
    priority if (item.value_high == DESC_DEVICE) begin
      desc_limit = lengths.device_len;
      desc_start = DEV_START;
      desc_kind  = XFER_DEVICE;
    end else if (item.value_high == DESC_CONFIG) begin
      desc_limit = lengths.config_len;
      desc_start = CONF_START;
      desc_kind  = XFER_CONFIG;
    end else if (item.value_high == DESC_STRING && item.value_low == STR_LANG) begin
      desc_limit = lengths.lang_len;
      desc_start = STR0_START;
      desc_kind  = XFER_STRING;
    end else if (item.value_high == DESC_STRING && item.value_low == STR_ONE) begin
      desc_limit = lengths.string1_len;
      desc_start = STR1_START;
      desc_kind  = XFER_STRING;
    end else if (item.value_high == DESC_STRING && item.value_low == STR_TWO) begin
      desc_limit = lengths.string2_len;
      desc_start = STR2_START;
      desc_kind  = XFER_STRING;
    end else begin
      desc_known = 1'b0;
    end
  end

  // clamp wlength to the descriptor and size the first packet
  always_comb begin
    clamped   = (item.length_requested >= {8'd0, desc_limit}) ? desc_limit
                                                              : item.length_requested[7:0];
    first_len = (clamped < MP) ? clamped : MP;
  end

  // follow-on packet: remaining count floors at zero
  always_comb begin
    rem_next    = (state.bytes_remaining > MP) ? state.bytes_remaining - MP : 8'd0;
    offset_next = state.read_offset + MP;
    cont_len    = (rem_next < MP) ? rem_next : MP;
  end

  // event dispatch
  always_comb begin
    result     = '0;
    state_next = state;
    unique case (item.event_kind)
      EV_BUS_RESET: begin
        state_next.read_offset = DEV_START;
        result.arm_out         = 1'b1;
        result.out_count       = STATUS_OUT_SIZE;
      end
      EV_IN_DONE: begin
        if (state.kind == XFER_STRING && state.string_index == STR_LANG) begin
          result.arm_out   = 1'b1;
          result.out_count = STATUS_OUT_SIZE;
        end else if (state.kind == XFER_DEVICE || state.kind == XFER_CONFIG ||
                     (state.kind == XFER_STRING &&
                      (state.string_index == STR_ONE || state.string_index == STR_TWO))) begin
          state_next.bytes_remaining = rem_next;
          if (rem_next != 8'd0) begin
            state_next.read_offset = offset_next;
            result.arm_in          = 1'b1;
            result.in_count        = cont_len[3:0];
            result.in_offset       = offset_next;
          end else begin
            result.arm_out   = 1'b1;
            result.out_count = STATUS_OUT_SIZE;
          end
        end
      end
      EV_OUT_DONE: begin
        if (item.token_pid == PID_SETUP) begin
          priority if (item.request_code == REQ_GET_STATUS) begin
            result.arm_out   = 1'b1;
            result.out_count = STATUS_OUT_SIZE;
          end else if (item.request_code == REQ_SET_ADDRESS ||
                       item.request_code == REQ_SET_CONFIGURATION ||
                       item.request_code == REQ_SET_INTERFACE) begin
            result.arm_in    = 1'b1;
            result.in_count  = 4'd0;
            result.in_offset = DEV_START;
          end else if (item.request_code == REQ_GET_DESCRIPTOR) begin
            // string requests record kind and index even when unknown
            if (item.value_high == DESC_STRING) begin
              state_next.kind         = XFER_STRING;
              state_next.string_index = item.value_low;
            end
            if (desc_known) begin
              state_next.kind            = desc_kind;
              state_next.read_offset     = desc_start;
              state_next.bytes_remaining = clamped;
              result.arm_in              = 1'b1;
              result.in_count            = first_len[3:0];
              result.in_offset           = desc_start;
            end
          end else begin
            result = '0;
          end
        end else if (item.token_pid == PID_OUT) begin
          result.arm_out   = 1'b1;
          result.out_count = OUT_SIZE;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule
